// ===== rtl/bsa_pkg.sv =====
// Shared types and constants of the branch span accumulator.
package bsa_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port (byte address 4 * index).
  localparam logic [1:0] REG_SPAN_LIMIT  = 2'd0;
  localparam logic [1:0] REG_MAX_BRANCH  = 2'd1;
  localparam logic [1:0] REG_SAMPLE_TYPE = 2'd2;

  localparam logic [31:0] SPAN_LIMIT_RST  = 32'd65536;
  localparam logic [5:0]  MAX_BRANCH_RST  = 6'd32;
  localparam logic [31:0] SAMPLE_TYPE_RST = 32'd9;

  typedef struct packed {
    logic [31:0] span_limit;
    logic [5:0]  max_branch_entries;
    logic [31:0] sample_type_code;
  } bsa_cfg_t;

  typedef struct packed {
    logic [31:0] sample_cnt;
    logic [31:0] entry_cnt;
    logic [63:0] span_total;
    logic        discarding;
    logic        record_end;
  } bsa_res_t;

endpackage

// ===== rtl/perf_branch_span_accumulator.sv =====
// Top level of the branch span accumulator: stream pipeline and configuration port.
//
// Usage:
//   The in_ channel carries one 64-bit ring buffer word per item in in_tdata.
//   in_tuser set asks for a clear of the statistics counters instead of a word;
//   in_tlast marks the last word before the ring head and returns the parser
//   to the header phase. Every input item gives exactly one result item on
//   the out_ channel with the span sum and the two counters after that item,
//   out_tuser set when the word was dropped and out_tlast set when it ended a
//   record.
//   An item lands in the input register at the edge where it is accepted and
//   its result enters the output register when that register can advance.
//   One item per cycle is sustained while out_tready is high; the path that
//   sets the clock is the branch span subtract, limit compare and 64-bit accumulate.
//   When the receiver stalls the output register holds its result and the
//   input register can still take one more item, so in_tready falls only
//   when both are full.
//   Reset (rst_n low, synchronous) empties both registers, puts the parser
//   in the header phase, zeroes the counters and loads the register defaults.
//   The user must write registers through the cfg_ port only while no item is
//   in flight; the block itself does not enforce this.
module perf_branch_span_accumulator #(
  parameter int COUNT_WIDTH = bsa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,    // [63:0] data_word
  input  logic                           in_tuser,    // [0] func
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [63:0] span_total, [95:64] entry_cnt, [127:96] sample_cnt
  output logic [127:0]                   out_tdata,
  output logic                           out_tuser,   // [0] discarding
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bsa_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bsa_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import bsa_pkg::*;

  bsa_cfg_t cfg;
  bsa_res_t res;
  bsa_res_t out_res_r;

  logic        s1_valid_r;
  logic        s1_func_r;
  logic [63:0] s1_word_r;
  logic        s1_drain_r;
  logic        out_valid_r;
  logic        out_adv;
  logic        s1_adv;
  logic        in_acc;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_tuser;
      s1_word_r  <= in_tdata;
      s1_drain_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  bsa_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bsa_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (s1_adv),
    .func    (s1_func_r),
    .word    (s1_word_r),
    .drain   (s1_drain_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.sample_cnt, out_res_r.entry_cnt, out_res_r.span_total};
  assign out_tuser  = out_res_r.discarding;
  assign out_tlast  = out_res_r.record_end;

endmodule

// ===== rtl/bsa_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
module bsa_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bsa_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bsa_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output bsa_pkg::bsa_cfg_t              cfg
);
  import bsa_pkg::*;

  logic [31:0] span_limit_r;
  logic [5:0]  max_branch_r;
  logic [31:0] sample_type_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_limit_r  <= SPAN_LIMIT_RST;
      max_branch_r  <= MAX_BRANCH_RST;
      sample_type_r <= SAMPLE_TYPE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SPAN_LIMIT:  span_limit_r  <= cfg_pwdata[31:0];
        REG_MAX_BRANCH:  max_branch_r  <= cfg_pwdata[5:0];
        REG_SAMPLE_TYPE: sample_type_r <= cfg_pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SPAN_LIMIT:  cfg_prdata = span_limit_r;
      REG_MAX_BRANCH:  cfg_prdata = {26'd0, max_branch_r};
      REG_SAMPLE_TYPE: cfg_prdata = sample_type_r;
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.span_limit         = span_limit_r;
  assign cfg.max_branch_entries = max_branch_r;
  assign cfg.sample_type_code   = sample_type_r;

endmodule

// ===== rtl/bsa_parser.sv =====
// Record parser state and statistics counters, updated once per processed item.
module bsa_parser #(
  parameter int COUNT_WIDTH = bsa_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_en,
  input  logic              func,
  input  logic [63:0]       word,
  input  logic              drain,
  input  bsa_pkg::bsa_cfg_t cfg,
  output bsa_pkg::bsa_res_t res
);
  import bsa_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_IP     = 3'd1;
  localparam logic [2:0] PH_NR     = 3'd2;
  localparam logic [2:0] PH_TRIPLE = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  logic [2:0]             phase_r, phase_nxt;
  logic [12:0]            wleft_r, wleft_nxt;
  logic [5:0]             branches_r, branches_nxt;
  logic [1:0]             tpos_r, tpos_nxt;
  logic [63:0]            from_r, from_nxt;
  logic [63:0]            sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0] acc_r, acc_nxt;
  logic [COUNT_WIDTH-1:0] vs_r, vs_nxt;
  logic                   disc_r, disc_nxt;

  logic [15:0] hdr_size;
  logic [12:0] hdr_wleft;
  logic [12:0] wleft_dec;
  logic [5:0]  branches_dec;
  logic        nr_ok;
  logic [63:0] diff_fw;
  logic [63:0] diff_wf;
  logic [63:0] span;
  logic        span_ok;
  logic        dropped;
  logic        rec_end;
  logic [63:0] acc_ext;
  logic [63:0] vs_ext;

  assign hdr_size     = word[63:48];
  assign hdr_wleft    = hdr_size[15:3] - 13'd1;
  assign wleft_dec    = wleft_r - 13'd1;
  assign branches_dec = branches_r - 6'd1;
  assign nr_ok        = (word != 64'd0) && (word[63:6] == 58'd0)
                        && (word[5:0] <= cfg.max_branch_entries);
  assign diff_fw      = from_r - word;
  assign diff_wf      = word - from_r;
  assign span         = (from_r > word) ? diff_fw : diff_wf;
  assign span_ok      = (span[63:32] == 32'd0) && (span[31:0] <= cfg.span_limit);

  always_comb begin
    phase_nxt    = phase_r;
    wleft_nxt    = wleft_r;
    branches_nxt = branches_r;
    tpos_nxt     = tpos_r;
    from_nxt     = from_r;
    sum_nxt      = sum_r;
    acc_nxt      = acc_r;
    vs_nxt       = vs_r;
    disc_nxt     = disc_r;
    dropped      = 1'b0;
    rec_end      = 1'b0;

    if (func) begin
      // A clear request consumes no word and leaves the parser alone.
      sum_nxt = '0;
      acc_nxt = '0;
      vs_nxt  = '0;
      dropped = disc_r;
    end else if (disc_r) begin
      dropped = 1'b1;
    end else if (phase_r == PH_HEADER) begin
      if (hdr_size < 16'd8) begin
        disc_nxt = 1'b1;
        dropped  = 1'b1;
      end else begin
        wleft_nxt    = hdr_wleft;
        branches_nxt = '0;
        tpos_nxt     = '0;
        if (hdr_wleft == 13'd0) begin
          rec_end   = 1'b1;
          phase_nxt = PH_HEADER;
        end else if (word[31:0] == cfg.sample_type_code) begin
          phase_nxt = PH_IP;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
    end else begin
      case (phase_r)
        PH_IP: phase_nxt = PH_NR;
        PH_NR: begin
          if (nr_ok) begin
            vs_nxt       = vs_r + COUNT_WIDTH'(1);
            branches_nxt = word[5:0];
            tpos_nxt     = '0;
            phase_nxt    = PH_TRIPLE;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_TRIPLE: begin
          if (tpos_r == 2'd0) begin
            from_nxt = word;
            tpos_nxt = 2'd1;
          end else if (tpos_r == 2'd1) begin
            if (span_ok) begin
              sum_nxt = sum_r + span;
              acc_nxt = acc_r + COUNT_WIDTH'(1);
            end
            tpos_nxt = 2'd2;
          end else begin
            tpos_nxt     = 2'd0;
            branches_nxt = branches_dec;
            if (branches_dec == 6'd0) begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        default: phase_nxt = PH_SKIP;
      endcase
      wleft_nxt = wleft_dec;
      if (wleft_dec == 13'd0) begin
        rec_end   = 1'b1;
        phase_nxt = PH_HEADER;
      end
    end

    // Drain end returns the parser to the header phase, even mid-record.
    if (!func && drain) begin
      phase_nxt    = PH_HEADER;
      wleft_nxt    = '0;
      branches_nxt = '0;
      tpos_nxt     = '0;
      disc_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      wleft_r    <= '0;
      branches_r <= '0;
      tpos_r     <= '0;
      from_r     <= '0;
      sum_r      <= '0;
      acc_r      <= '0;
      vs_r       <= '0;
      disc_r     <= 1'b0;
    end else if (item_en) begin
      phase_r    <= phase_nxt;
      wleft_r    <= wleft_nxt;
      branches_r <= branches_nxt;
      tpos_r     <= tpos_nxt;
      from_r     <= from_nxt;
      sum_r      <= sum_nxt;
      acc_r      <= acc_nxt;
      vs_r       <= vs_nxt;
      disc_r     <= disc_nxt;
    end
  end

  assign acc_ext = 64'(acc_nxt);
  assign vs_ext  = 64'(vs_nxt);

  assign res.span_total = sum_nxt;
  assign res.entry_cnt  = acc_ext[31:0];
  assign res.sample_cnt = vs_ext[31:0];
  assign res.discarding = dropped;
  assign res.record_end = rec_end;

`ifndef SYNTHESIS
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (item_en && func) |=> (sum_r == 64'd0 && acc_r == '0 && vs_r == '0))
    else $error("clear request did not zero the counters");

  a_drain_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (item_en && !func && drain) |=> (phase_r == PH_HEADER && !disc_r && wleft_r == 13'd0))
    else $error("drain end did not return the parser to the header phase");

  a_discard_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (item_en && !func && disc_r) |=> (sum_r == $past(sum_r) && acc_r == $past(acc_r)
                                      && vs_r == $past(vs_r)))
    else $error("counters moved while words were being discarded");

  a_discard_from_header: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(disc_r) |-> ($past(phase_r) == PH_HEADER))
    else $error("discard mode entered outside the header phase");
`endif

endmodule
